>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by cbm_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// delayed implication
`define ASSERT_LATER2(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// shared types and codes of the cartridge bank mapper
// ----------------------------------------------------------------------------
package cbm_pkg;

	// store capacities
	localparam int RomAddrBitsDef = 22;
	localparam int RamAddrBitsDef = 17;

	// width of a ROM offset before masking (ExHiROM sets bit 22)
	localparam int RomOffW = 23;
	// width of a battery RAM offset before masking
	localparam int RamOffW = 19;

	// configuration port
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 4;

	localparam logic [CfgIdxW-1:0] CfgMapType  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgRomShift = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgRamShift = 2'd2;

	// map types
	localparam logic [1:0] MapNone   = 2'd0;
	localparam logic [1:0] MapLoRom  = 2'd1;
	localparam logic [1:0] MapHiRom  = 2'd2;
	localparam logic [1:0] MapExHiRom = 2'd3;

	// request modes
	localparam logic [1:0] ModeRead  = 2'd0;
	localparam logic [1:0] ModeWrite = 2'd1;
	localparam logic [1:0] ModeLoad  = 2'd2;

	// result sources
	localparam logic [1:0] SrcOpen = 2'd0;
	localparam logic [1:0] SrcRom  = 2'd1;
	localparam logic [1:0] SrcRam  = 2'd2;

	// configuration reset values
	localparam logic [1:0] MapTypeReset  = MapLoRom;
	localparam logic [3:0] RomShiftReset = 4'd12;
	localparam logic [2:0] RamShiftReset = 3'd3;

	// decoded control for one request
	typedef struct packed {
		logic       rd;
		logic       ram_we;
		logic       rom_we;
		logic [1:0] src;
	} dec_ctl_t;

endpackage

>>> rtl/core/cbm_if.sv
// ----------------------------------------------------------------------------
// cbm_if
// request, response and configuration channels of the mapper
// ----------------------------------------------------------------------------
interface cbm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] bank;
	logic [15:0] offset_addr;
	logic [7:0] write_data;
	logic [7:0] open_bus_value;

	modport source (output valid, mode, bank, offset_addr, write_data, open_bus_value,
		input ready);
	modport sink (input valid, mode, bank, offset_addr, write_data, open_bus_value,
		output ready);
endinterface

interface cbm_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	// where the byte came from: open bus, ROM or battery RAM
	logic [1:0] rd_source;

	modport source (output valid, read_data, rd_source, input ready);
	modport sink (input valid, read_data, rd_source, output ready);
endinterface

interface cbm_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [cbm_pkg::CfgIdxW-1:0]  index;
	logic [cbm_pkg::CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/cartridge_bank_mapper_top.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_top
// a bus read passes the memory read registers with stage 1, then the output register
// throughput: one request per cycle while the result sink keeps up and no RAM clear runs
// reset: config returns to LoROM, ROM 4 MiB, RAM 8 KiB; battery RAM is then
// zeroed one byte a cycle with requests held off
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_top #(
	parameter int ROM_ADDR_BITS = cbm_pkg::RomAddrBitsDef,
	parameter int RAM_ADDR_BITS = cbm_pkg::RamAddrBitsDef
) (
	input  logic      clk,
	input  logic      arst_n,
	cbm_req_if.sink   req,
	cbm_rsp_if.source rsp,
	cbm_cfg_if.sink   cfg
);

	localparam int RomDepth = 1 << ROM_ADDR_BITS;
	localparam int RamDepth = 1 << RAM_ADDR_BITS;

	// configuration registers
	logic [1:0] map_type_q;
	logic [3:0] rom_shift_q;
	logic [2:0] ram_shift_q;

	// battery RAM clearing pass
	logic                     clearing_q;
	logic [RAM_ADDR_BITS-1:0] clr_q;

	// decode of the request on the port
	cbm_pkg::dec_ctl_t        ctl;
	logic [RAM_ADDR_BITS-1:0] ram_addr;
	logic [ROM_ADDR_BITS-1:0] rom_addr;

	// memories and their registered read data
	logic [7:0] rom_mem [RomDepth];
	logic [7:0] ram_mem [RamDepth];
	logic [7:0] rom_rd_q;
	logic [7:0] ram_rd_q;

	// stage 1: read in flight while the memories answer
	logic       valid_s1;
	logic [1:0] src_s1;
	logic [7:0] ob_s1;

	// output register
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic [1:0] out_src_q;

	logic req_fire;
	logic out_free;

	// config writes land at any time; the port never back-pressures
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_type_q  <= cbm_pkg::MapTypeReset;
			rom_shift_q <= cbm_pkg::RomShiftReset;
			ram_shift_q <= cbm_pkg::RamShiftReset;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				cbm_pkg::CfgMapType:  map_type_q  <= cfg.data[1:0];
				cbm_pkg::CfgRomShift: rom_shift_q <= cfg.data;
				cbm_pkg::CfgRamShift: ram_shift_q <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	// sweep the battery RAM to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	cbm_decode #(
		.ROM_ADDR_BITS(ROM_ADDR_BITS),
		.RAM_ADDR_BITS(RAM_ADDR_BITS)
	) u_decode (
		.map_type    (map_type_q),
		.rom_shift   (rom_shift_q),
		.ram_shift   (ram_shift_q),
		.mode        (req.mode),
		.bank        (req.bank),
		.offset_addr (req.offset_addr),
		.ctl         (ctl),
		.ram_addr    (ram_addr),
		.rom_addr    (rom_addr)
	);

	// the output register frees up when empty or being drained this cycle;
	// stage 1 moves on only then, and a new request is taken only when stage 1
	// can move, so the memory read registers never get overwritten early
	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = !clearing_q && (!valid_s1 || out_free);
	assign req_fire  = req.valid && req.ready;

	// ROM: one write port for loads, one registered read port.
	// each request reads or writes, never both, so the same entry is never
	// read and written at one edge; a write is visible to the next request
	always_ff @(posedge clk) begin
		if (req_fire && ctl.rom_we) begin
			rom_mem[rom_addr] <= req.write_data;
		end
		if (req_fire && ctl.rd) begin
			rom_rd_q <= rom_mem[rom_addr];
		end
	end

	// battery RAM: the clearing sweep owns the write port until it is done
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			ram_mem[clr_q] <= '0;
		end else if (req_fire && ctl.ram_we) begin
			ram_mem[ram_addr] <= req.write_data;
		end
		if (req_fire && ctl.rd) begin
			ram_rd_q <= ram_mem[ram_addr];
		end
	end

	// stage 1 control; only reads carry on to a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || out_free) begin
			valid_s1 <= req_fire && ctl.rd;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			src_s1 <= ctl.src;
			ob_s1  <= req.open_bus_value;
		end
	end

	// output register, held while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && out_free) begin
			out_src_q <= src_s1;
			unique case (src_s1)
				cbm_pkg::SrcRam: out_data_q <= ram_rd_q;
				cbm_pkg::SrcRom: out_data_q <= rom_rd_q;
				default:         out_data_q <= ob_s1;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;
	assign rsp.rd_source = out_src_q;

endmodule

>>> rtl/core/cbm_decode.sv
// ----------------------------------------------------------------------------
// cbm_decode
// bank:address decode into ROM / battery RAM offsets and request control
// ----------------------------------------------------------------------------
module cbm_decode #(
	parameter int ROM_ADDR_BITS = cbm_pkg::RomAddrBitsDef,
	parameter int RAM_ADDR_BITS = cbm_pkg::RamAddrBitsDef
) (
	input  logic [1:0]               map_type,
	input  logic [3:0]               rom_shift,
	input  logic [2:0]               ram_shift,
	input  logic [1:0]               mode,
	input  logic [7:0]               bank,
	input  logic [15:0]              offset_addr,
	output cbm_pkg::dec_ctl_t        ctl,
	output logic [RAM_ADDR_BITS-1:0] ram_addr,
	output logic [ROM_ADDR_BITS-1:0] rom_addr
);

	localparam logic [3:0] RomShiftMax = 4'(ROM_ADDR_BITS - 10);
	localparam logic [2:0] RamShiftMax = 3'(RAM_ADDR_BITS - 10);

	logic [3:0]                  rom_s;
	logic [2:0]                  ram_s;
	logic [ROM_ADDR_BITS-1:0]    rom_mask;
	logic [RAM_ADDR_BITS-1:0]    ram_mask;
	logic                        lo_ram_hit;
	logic                        hi_ram_hit;
	logic                        ram_hit;
	logic                        rom_hit;
	logic                        ex_hi;
	logic [cbm_pkg::RamOffW-1:0] ram_off;
	logic [cbm_pkg::RomOffW-1:0] rom_off;
	logic [23:0]                 load_off;

	// size masks with the shifts clamped to capacity
	always_comb begin
		rom_s = (rom_shift > RomShiftMax) ? RomShiftMax : rom_shift;
		ram_s = (ram_shift > RamShiftMax) ? RamShiftMax : ram_shift;
		for (int i = 0; i < ROM_ADDR_BITS; i++) begin
			rom_mask[i] = (i < 10 + int'(rom_s));
		end
		for (int i = 0; i < RAM_ADDR_BITS; i++) begin
			ram_mask[i] = (i < 10 + int'(ram_s));
		end
	end

	// battery RAM windows
	assign lo_ram_hit = ((bank >= 8'h70 && bank < 8'h7e) || bank >= 8'hf0) && !offset_addr[15];
	assign hi_ram_hit = !bank[6] && (offset_addr[15:13] == 3'b011);
	assign ram_hit    = (map_type == cbm_pkg::MapLoRom) ? lo_ram_hit : hi_ram_hit;
	assign rom_hit    = offset_addr[15] || bank[6];
	assign ex_hi      = (map_type == cbm_pkg::MapExHiRom) && !bank[7];

	always_comb begin
		if (map_type == cbm_pkg::MapLoRom) begin
			ram_off = {bank[3:0], offset_addr[14:0]};
			rom_off = {1'b0, bank[6:0], offset_addr[14:0]};
		end else begin
			ram_off = {bank[5:0], offset_addr[12:0]};
			rom_off = {ex_hi, bank[5:0], offset_addr};
		end
	end

	assign load_off = {bank, offset_addr};
	assign ram_addr = ram_off[RAM_ADDR_BITS-1:0] & ram_mask;
	assign rom_addr = (mode == cbm_pkg::ModeLoad) ? load_off[ROM_ADDR_BITS-1:0]
		: (rom_off[ROM_ADDR_BITS-1:0] & rom_mask);

	always_comb begin
		ctl.rd     = (mode == cbm_pkg::ModeRead);
		ctl.ram_we = (mode == cbm_pkg::ModeWrite) && (map_type != cbm_pkg::MapNone) && ram_hit;
		ctl.rom_we = (mode == cbm_pkg::ModeLoad);
		unique case (map_type)
			cbm_pkg::MapNone: ctl.src = cbm_pkg::SrcOpen;
			default: begin
				if (ram_hit) begin
					ctl.src = cbm_pkg::SrcRam;
				end else if (rom_hit) begin
					ctl.src = cbm_pkg::SrcRom;
				end else begin
					ctl.src = cbm_pkg::SrcOpen;
				end
			end
		endcase
	end

endmodule

>>> rtl/core/cbm_checker.sv
// ----------------------------------------------------------------------------
// cbm_checker
// port-level checks on the mapper, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [1:0] req_mode,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_read_data,
	input logic [1:0] rsp_source
);

	// a stalled result stays offered
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// a stalled result keeps its payload
	`ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready,
		$stable(rsp_read_data) && $stable(rsp_source))

	// a result names open bus, ROM or battery RAM only
	`ASSERT_IMPLY(a_src_legal, clk, arst_n, rsp_valid,
		rsp_source == cbm_pkg::SrcOpen || rsp_source == cbm_pkg::SrcRom
		|| rsp_source == cbm_pkg::SrcRam)

	// a read taken with the output empty is offered once it has passed stage 1 and the output register
	`ASSERT_LATER2(a_rd_latency, clk, arst_n,
		req_valid && req_ready && req_mode == cbm_pkg::ModeRead && !rsp_valid, rsp_valid)

endmodule

bind cartridge_bank_mapper_top cbm_checker u_cbm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_mode      (req.mode),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_data (rsp.read_data),
	.rsp_source    (rsp.rd_source)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking regression of the cartridge bank mapper: random and directed
// bus requests run against a behavioural copy of the decode, the battery RAM
// and the ROM image, across every map type and a spread of size settings
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// the one request mode the block ignores
	localparam logic [1:0] ModeUnused = 2'd3;

	localparam int unsigned RomCap = 1 << cbm_pkg::RomAddrBitsDef;
	localparam int unsigned RamCap = 1 << cbm_pkg::RamAddrBitsDef;

	localparam int NumPhases     = 9;
	localparam int ItemsPerPhase = 215;
	// time for a read to settle, with a little margin on top
	localparam int SettleCycles  = 4;
	localparam int TailCycles    = 10;
	// the post-reset RAM clear is by far the longest quiet stretch
	localparam int IdleLimit     = 3 * (1 << cbm_pkg::RamAddrBitsDef);

	// one bus request as queued for the driver
	typedef struct packed {
		logic       hold;
		logic [1:0] mode;
		logic [7:0] bank;
		logic [15:0] adr;
		logic [7:0] wdata;
		logic [7:0] obus;
	} bus_req_t;

	// one read result
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] src;
	} read_rsp_t;

	// mapper register settings
	typedef struct packed {
		logic [1:0] map;
		logic [3:0] rom_sh;
		logic [2:0] ram_sh;
	} map_cfg_t;

	logic clk;
	logic arst_n;

	cbm_req_if bus_req();
	cbm_rsp_if bus_rsp();
	cbm_cfg_if cfg_wr();

	cartridge_bank_mapper_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (bus_req),
		.rsp    (bus_rsp),
		.cfg    (cfg_wr)
	);

	// requests waiting to be driven, and read results still owed by the block
	bus_req_t  bus_q [$];
	read_rsp_t read_q [$];

	// behavioural images of the cartridge stores
	logic [7:0] rom_img [int unsigned];
	logic [7:0] ram_img [0:RamCap-1];

	// settings as the block holds them (tracked at the write handshake)
	map_cfg_t live_cfg;
	// settings the request generator is working to
	map_cfg_t gen_cfg;
	// ROM entries that some queued load has already filled
	bit rom_loaded [int unsigned];

	map_cfg_t phase_plan [NumPhases];

	int send_idle_pct;
	int recv_idle_pct;
	int phase_items;
	logic req_taken;
	bus_req_t nxt;
	int fails;
	int quiet;

	// coverage tallies for the closing summary
	int n_read [3];
	int n_write;
	int n_load;
	int n_ignored;

	// ------------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// address decode: which store an access lands in and at what offset
	// shared by the request generator (to keep reads off unloaded ROM) and
	// by the result prediction
	// ------------------------------------------------------------------------
	function automatic void map_access(input map_cfg_t c, input logic [7:0] bank,
			input logic [15:0] adr, output logic [1:0] src, output int unsigned off);
		int unsigned bk, ad, b7, rs, ms, rom_m, ram_m;
		bk = bank;
		ad = adr;
		b7 = bk & 32'h7f;
		// oversized shifts are clamped to what the stores can hold
		rs = (c.rom_sh > cbm_pkg::RomAddrBitsDef - 10) ? cbm_pkg::RomAddrBitsDef - 10
			: c.rom_sh;
		ms = (c.ram_sh > cbm_pkg::RamAddrBitsDef - 10) ? cbm_pkg::RamAddrBitsDef - 10
			: c.ram_sh;
		rom_m = (32'd1024 << rs) - 1;
		ram_m = (32'd1024 << ms) - 1;
		src = cbm_pkg::SrcOpen;
		off = 0;
		case (c.map)
			cbm_pkg::MapLoRom: begin
				// save RAM in banks 70-7d and f0-ff, lower half of the bank
				if (((bk >= 32'h70 && bk < 32'h7e) || bk >= 32'hf0) && ad < 32'h8000) begin
					src = cbm_pkg::SrcRam;
					off = (((bk & 32'hf) << 15) | ad) & ram_m;
				end else if (ad >= 32'h8000 || b7 >= 32'h40) begin
					src = cbm_pkg::SrcRom;
					off = ((b7 << 15) | (ad & 32'h7fff)) & rom_m;
				end
			end
			cbm_pkg::MapHiRom, cbm_pkg::MapExHiRom: begin
				// save RAM window 6000-7fff in banks 00-3f / 80-bf
				if (b7 < 32'h40 && ad >= 32'h6000 && ad < 32'h8000) begin
					src = cbm_pkg::SrcRam;
					off = (((bk & 32'h3f) << 13) | (ad & 32'h1fff)) & ram_m;
				end else if (ad >= 32'h8000 || b7 >= 32'h40) begin
					src = cbm_pkg::SrcRom;
					off = ((b7 & 32'h3f) << 16) | ad;
					// ExHiROM sets bit 22 for the lower banks, which the image cap then masks off
					if (c.map == cbm_pkg::MapExHiRom && bk < 32'h80)
						off = off | 32'h400000;
					off = off & rom_m & (RomCap - 1);
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// prediction: apply one accepted request to the store images and, for a
	// read, queue the result the block owes
	// ------------------------------------------------------------------------
	task automatic predict_access(input bus_req_t r);
		logic [1:0] src;
		int unsigned off;
		read_rsp_t exp_rsp;
		map_access(live_cfg, r.bank, r.adr, src, off);
		case (r.mode)
			cbm_pkg::ModeLoad: begin
				// load offset is the full bus address, capped to the image only
				rom_img[{r.bank, r.adr} & (RomCap - 1)] = r.wdata;
				n_load++;
			end
			cbm_pkg::ModeWrite: begin
				// writes only ever reach battery RAM; map none decodes to open bus
				if (src == cbm_pkg::SrcRam)
					ram_img[off] = r.wdata;
				n_write++;
			end
			cbm_pkg::ModeRead: begin
				exp_rsp.src = src;
				if (src == cbm_pkg::SrcRam)
					exp_rsp.data = ram_img[off];
				else if (src == cbm_pkg::SrcRom)
					exp_rsp.data = rom_img.exists(off) ? rom_img[off] : 8'h00;
				else
					exp_rsp.data = r.obus;
				read_q.push_back(exp_rsp);
				n_read[src]++;
			end
			default: n_ignored++;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// request generation
	// ------------------------------------------------------------------------
	// queue one request; a read that would land on ROM never loaded gets a
	// load of that entry queued ahead of it
	task automatic queue_access(input logic [1:0] mode, input logic [7:0] bank,
			input logic [15:0] adr, input logic [7:0] wdata, input logic [7:0] obus,
			input logic hold);
		logic [1:0] src;
		int unsigned off;
		bus_req_t r;
		if (mode == cbm_pkg::ModeRead) begin
			map_access(gen_cfg, bank, adr, src, off);
			if (src == cbm_pkg::SrcRom && !rom_loaded.exists(off)) begin
				r.hold  = 1'b0;
				r.mode  = cbm_pkg::ModeLoad;
				// the top two bank bits fall outside the image and are don't-care
				r.bank  = {2'($urandom_range(0, 3)), 6'(off >> 16)};
				r.adr   = 16'(off);
				r.wdata = 8'($urandom);
				r.obus  = 8'($urandom);
				bus_q.push_back(r);
				rom_loaded[off] = 1'b1;
				phase_items++;
			end
		end
		if (mode == cbm_pkg::ModeLoad)
			rom_loaded[{bank, adr} & (RomCap - 1)] = 1'b1;
		r.hold  = hold;
		r.mode  = mode;
		r.bank  = bank;
		r.adr   = adr;
		r.wdata = wdata;
		r.obus  = obus;
		bus_q.push_back(r);
		if (mode != ModeUnused)
			phase_items++;
	endtask

	// random request, steered at the RAM and ROM windows most of the time
	task automatic queue_random(input logic hold);
		logic [7:0] bank_edges [14] = '{8'h00, 8'h3f, 8'h40, 8'h6f, 8'h70, 8'h7d, 8'h7e,
			8'h7f, 8'h80, 8'hbf, 8'hc0, 8'hef, 8'hf0, 8'hff};
		logic [15:0] adr_edges [7] = '{16'h0000, 16'h1fff, 16'h5fff, 16'h6000, 16'h7fff,
			16'h8000, 16'hffff};
		int pick;
		logic [1:0] mode;
		logic [7:0] bank;
		logic [15:0] adr;
		pick = $urandom_range(0, 99);
		if (pick < 48)
			mode = cbm_pkg::ModeRead;
		else if (pick < 75)
			mode = cbm_pkg::ModeWrite;
		else if (pick < 95)
			mode = cbm_pkg::ModeLoad;
		else
			mode = ModeUnused;
		case ($urandom_range(0, 3))
			0: begin
				bank = 8'($urandom);
				adr  = 16'($urandom);
			end
			1: begin
				// LoROM save RAM banks
				bank = $urandom_range(0, 1) ? 8'(8'h70 + $urandom_range(0, 13))
					: 8'(8'hf0 + $urandom_range(0, 15));
				adr  = 16'($urandom_range(0, 16'h7fff));
			end
			2: begin
				// HiROM save RAM window
				bank = {1'($urandom), 1'b0, 6'($urandom)};
				adr  = 16'(16'h6000 + $urandom_range(0, 16'h1fff));
			end
			default: begin
				bank = 8'($urandom);
				adr  = 16'(16'h8000 + $urandom_range(0, 16'h7fff));
			end
		endcase
		if ($urandom_range(0, 6) == 0)
			bank = bank_edges[$urandom_range(0, 13)];
		if ($urandom_range(0, 6) == 0)
			adr = adr_edges[$urandom_range(0, 6)];
		queue_access(mode, bank, adr, 8'($urandom), 8'($urandom), hold);
	endtask

	// ------------------------------------------------------------------------
	// phase control
	// ------------------------------------------------------------------------
	// block is idle once the driver is empty and every read has answered
	task automatic wait_drained();
		while (bus_q.size() != 0 || bus_req.valid || read_q.size() != 0)
			@(posedge clk);
	endtask

	// one register write over the configuration channel, held until taken
	task automatic write_reg(input logic [cbm_pkg::CfgIdxW-1:0] idx,
			input logic [cbm_pkg::CfgDataW-1:0] val);
		@(negedge clk);
		cfg_wr.valid <= 1'b1;
		cfg_wr.index <= idx;
		cfg_wr.data  <= val;
		do @(posedge clk); while (!cfg_wr.ready);
	endtask

	initial begin
		int ph;
		logic held_once;

		// every block input known from time zero
		arst_n = 1'b0;
		bus_req.valid          = 1'b0;
		bus_req.mode           = cbm_pkg::ModeRead;
		bus_req.bank           = '0;
		bus_req.offset_addr    = '0;
		bus_req.write_data     = '0;
		bus_req.open_bus_value = '0;
		bus_rsp.ready          = 1'b0;
		cfg_wr.valid           = 1'b0;
		cfg_wr.index           = cbm_pkg::CfgMapType;
		cfg_wr.data            = '0;
		req_taken = 1'b0;
		fails = 0;
		quiet = 0;
		n_read = '{0, 0, 0};
		n_write = 0;
		n_load = 0;
		n_ignored = 0;
		foreach (ram_img[i])
			ram_img[i] = 8'h00;

		live_cfg = '{cbm_pkg::MapTypeReset, cbm_pkg::RomShiftReset, cbm_pkg::RamShiftReset};
		gen_cfg  = live_cfg;

		// first phase runs on the reset settings; the rest cover every map
		// type, the smallest sizes and the clamped oversize shifts
		phase_plan = '{
			'{cbm_pkg::MapTypeReset, cbm_pkg::RomShiftReset, cbm_pkg::RamShiftReset},
			'{cbm_pkg::MapLoRom,   4'd0,  3'd0},
			'{cbm_pkg::MapHiRom,   4'd13, 3'd7},
			'{cbm_pkg::MapExHiRom, 4'd12, 3'd7},
			'{cbm_pkg::MapNone,    4'd5,  3'd2},
			'{cbm_pkg::MapExHiRom, 4'd3,  3'd0},
			'{cbm_pkg::MapHiRom,   4'd1,  3'd4},
			'{cbm_pkg::MapLoRom,   4'd13, 3'd7},
			'{cbm_pkg::MapExHiRom, 4'd0,  3'd1}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (ph = 0; ph < NumPhases; ph++) begin
			if (ph > 0) begin
				// registers change only with the block idle
				wait_drained();
				repeat (SettleCycles) @(posedge clk);
				gen_cfg = phase_plan[ph];
				write_reg(cbm_pkg::CfgMapType,  cbm_pkg::CfgDataW'(gen_cfg.map));
				write_reg(cbm_pkg::CfgRomShift, gen_cfg.rom_sh);
				write_reg(cbm_pkg::CfgRamShift, cbm_pkg::CfgDataW'(gen_cfg.ram_sh));
				@(negedge clk);
				cfg_wr.valid <= 1'b0;
			end

			// stall mix: receiver-heavy, then sender-heavy, then none
			if (ph < 3) begin
				send_idle_pct = 34;
				recv_idle_pct = 46;
			end else if (ph < 6) begin
				send_idle_pct = 46;
				recv_idle_pct = 34;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			phase_items = 0;
			held_once = 1'b0;

			if (ph == 0) begin
				// LoROM on reset sizes: cleared RAM, both save RAM bank ranges
				// (f0 and up now writable), mirroring, bank edges, open bus,
				// a load with the upper bank bits set, and an ignored mode
				queue_access(cbm_pkg::ModeRead,  8'h70, 16'h0000, 8'h00, 8'h00, 1'b0);
				queue_access(cbm_pkg::ModeWrite, 8'hff, 16'h7fff, 8'hff, 8'h00, 1'b0);
				queue_access(cbm_pkg::ModeRead,  8'hff, 16'h7fff, 8'h00, 8'h00, 1'b0);
				queue_access(cbm_pkg::ModeWrite, 8'hf0, 16'h0000, 8'ha5, 8'h00, 1'b0);
				queue_access(cbm_pkg::ModeRead,  8'hf0, 16'h0000, 8'h00, 8'h00, 1'b0);
				queue_access(cbm_pkg::ModeRead,  8'h70, 16'h0000, 8'h00, 8'h00, 1'b0);
				queue_access(cbm_pkg::ModeWrite, 8'h7d, 16'h1234, 8'h3c, 8'h00, 1'b0);
				queue_access(cbm_pkg::ModeRead,  8'h7d, 16'h1234, 8'h00, 8'h00, 1'b0);
				queue_access(cbm_pkg::ModeRead,  8'h7e, 16'h0000, 8'h00, 8'h00, 1'b0);
				queue_access(cbm_pkg::ModeRead,  8'h00, 16'h0000, 8'h00, 8'hff, 1'b0);
				queue_access(cbm_pkg::ModeRead,  8'h3f, 16'h7fff, 8'h00, 8'h55, 1'b0);
				queue_access(cbm_pkg::ModeLoad,  8'hff, 16'hffff, 8'h5a, 8'h00, 1'b0);
				queue_access(cbm_pkg::ModeRead,  8'hff, 16'hffff, 8'h00, 8'h00, 1'b0);
				queue_access(cbm_pkg::ModeRead,  8'h80, 16'h8000, 8'h00, 8'h00, 1'b0);
				queue_access(cbm_pkg::ModeRead,  8'h00, 16'hffff, 8'h00, 8'h00, 1'b0);
				queue_access(ModeUnused,         8'hff, 16'hffff, 8'hff, 8'hff, 1'b0);
				queue_access(cbm_pkg::ModeWrite, 8'h00, 16'h0000, 8'h77, 8'h00, 1'b0);
				queue_access(cbm_pkg::ModeRead,  8'h6f, 16'h7fff, 8'h00, 8'haa, 1'b0);
			end

			while (phase_items < ItemsPerPhase) begin
				// once a phase the sender holds off until the reads have drained
				if (!held_once && phase_items >= ItemsPerPhase / 2) begin
					held_once = 1'b1;
					queue_random(1'b1);
				end else begin
					queue_random(1'b0);
				end
			end
		end

		wait_drained();
		repeat (TailCycles) @(posedge clk);
		if (read_q.size() != 0)
			fails += read_q.size();

		$display("covered %0d reads (%0d ROM, %0d save RAM, %0d open bus), %0d writes,",
			n_read[cbm_pkg::SrcRom] + n_read[cbm_pkg::SrcRam] + n_read[cbm_pkg::SrcOpen],
			n_read[cbm_pkg::SrcRom], n_read[cbm_pkg::SrcRam], n_read[cbm_pkg::SrcOpen],
			n_write);
		$display("%0d ROM loads and %0d ignored requests over %0d mapper settings",
			n_load, n_ignored, NumPhases);
		if (fails == 0)
			$display("cartridge_bank_mapper_top regression: pass");
		else
			$display("cartridge_bank_mapper_top regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// request driver: a request stays up until taken, then the next one goes
	// out unless the sender idles this cycle or must wait for reads to drain
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		req_taken <= bus_req.valid && bus_req.ready;
	end

	always @(negedge clk) begin
		if (arst_n && (!bus_req.valid || req_taken)) begin
			if (bus_q.size() != 0 && !(bus_q[0].hold && read_q.size() != 0)
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = bus_q.pop_front();
				bus_req.valid          <= 1'b1;
				bus_req.mode           <= nxt.mode;
				bus_req.bank           <= nxt.bank;
				bus_req.offset_addr    <= nxt.adr;
				bus_req.write_data     <= nxt.wdata;
				bus_req.open_bus_value <= nxt.obus;
			end else begin
				bus_req.valid <= 1'b0;
			end
		end
	end

	// result sink back-pressure
	always @(negedge clk) begin
		bus_rsp.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------------
	// monitor: track settings and requests as they are taken, check results
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		bus_req_t  seen;
		read_rsp_t exp_rsp;
		if (arst_n) begin
			if (cfg_wr.valid && cfg_wr.ready) begin
				case (cfg_wr.index)
					cbm_pkg::CfgMapType:  live_cfg.map    = cfg_wr.data[1:0];
					cbm_pkg::CfgRomShift: live_cfg.rom_sh = cfg_wr.data;
					cbm_pkg::CfgRamShift: live_cfg.ram_sh = cfg_wr.data[2:0];
					default: ;
				endcase
			end

			if (bus_req.valid && bus_req.ready) begin
				seen.hold  = 1'b0;
				seen.mode  = bus_req.mode;
				seen.bank  = bus_req.bank;
				seen.adr   = bus_req.offset_addr;
				seen.wdata = bus_req.write_data;
				seen.obus  = bus_req.open_bus_value;
				predict_access(seen);
			end

			if (bus_rsp.valid && bus_rsp.ready) begin
				if (read_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected read result: data %h source %0d",
							bus_rsp.read_data, bus_rsp.rd_source);
				end else begin
					exp_rsp = read_q.pop_front();
					if (bus_rsp.read_data !== exp_rsp.data
							|| bus_rsp.rd_source !== exp_rsp.src) begin
						fails++;
						if (fails <= 10)
							$display("read result mismatch: data exp %h got %h, source exp %0d got %0d",
								exp_rsp.data, bus_rsp.read_data, exp_rsp.src,
								bus_rsp.rd_source);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long without any handshake on any channel
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((bus_req.valid && bus_req.ready) || (bus_rsp.valid && bus_rsp.ready)
				|| (cfg_wr.valid && cfg_wr.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IdleLimit) begin
			$display("timeout after %0d cycles without a handshake", quiet);
			$display("cartridge_bank_mapper_top regression: fail");
			$finish;
		end
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/cbm_pkg.sv
rtl/core/cbm_if.sv
rtl/core/cbm_decode.sv
rtl/core/cartridge_bank_mapper_top.sv
rtl/core/cbm_checker.sv
tb/tb_top.sv
